// ===== sv/battery_soc_estimator_macros.svh =====
// Assertion macros for the battery state-of-charge estimator.
`ifndef BATTERY_SOC_ESTIMATOR_MACROS_SVH
`define BATTERY_SOC_ESTIMATOR_MACROS_SVH

`ifndef ASSERT_OFF
`define BSE_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("battery_soc_estimator: assertion failed");
`define BSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("battery_soc_estimator: assertion failed");
`else
`define BSE_ASSERT(label, clk, rst_n, prop)
`define BSE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/bse_pkg.sv =====
package bse_pkg;

  localparam int AdcBits     = 12;
  localparam int SampleW     = 12;
  localparam int PackW       = 26;
  localparam int PctW        = 15;
  localparam int CellsW      = 4;
  localparam int UvPerCountW = 16;
  localparam int WeightW     = 17;
  localparam int FullCellW   = 13;
  localparam int TablePoints = 21;
  localparam int IdxW        = 5;
  localparam int MulAW       = 28;
  localparam int MulBW       = 17;
  localparam int ProdW       = MulAW + MulBW;
  localparam int AccW        = ProdW + 1;
  localparam int DivW        = 18;
  localparam int CntW        = 5;
  localparam int IdivBits    = 11;
  localparam int PctStep     = 1280;
  localparam int WeightOne   = 65536;
  localparam int MvToUv      = 1000;
  localparam int RoundHalf   = 32768;
  localparam int FracBits    = 16;

  localparam logic [PackW-1:0] PackMax = '1;

  typedef enum logic [3:0] {
    OpNone,
    OpAccept,
    OpPrimeA,
    OpPrimeB,
    OpPrimeC,
    OpScale,
    OpMulNew,
    OpMulOld,
    OpFilter,
    OpCdivLoad,
    OpDivStep,
    OpRange,
    OpSearch,
    OpInterpMul,
    OpIdivLoad,
    OpPct
  } op_e;

  typedef struct packed {
    logic [CellsW-1:0]      cell_count;
    logic [UvPerCountW-1:0] uv_per_count;
    logic [WeightW-1:0]     weight;
    logic [FullCellW-1:0]   full_cell_mv;
  } cfg_t;

  typedef struct packed {
    logic primed;
    logic div_last;
    logic below_min;
    logic above_max;
    logic seg_found;
  } status_t;

  function automatic logic [PackW-1:0] soc_volt_uv(input logic [IdxW-1:0] idx);
    logic [PackW-1:0] v;
    case (idx)
      5'd0:    v = 26'd3300000;
      5'd1:    v = 26'd3500000;
      5'd2:    v = 26'd3600000;
      5'd3:    v = 26'd3650000;
      5'd4:    v = 26'd3680000;
      5'd5:    v = 26'd3700000;
      5'd6:    v = 26'd3720000;
      5'd7:    v = 26'd3740000;
      5'd8:    v = 26'd3760000;
      5'd9:    v = 26'd3780000;
      5'd10:   v = 26'd3800000;
      5'd11:   v = 26'd3830000;
      5'd12:   v = 26'd3850000;
      5'd13:   v = 26'd3880000;
      5'd14:   v = 26'd3920000;
      5'd15:   v = 26'd3960000;
      5'd16:   v = 26'd4000000;
      5'd17:   v = 26'd4060000;
      5'd18:   v = 26'd4100000;
      5'd19:   v = 26'd4150000;
      default: v = 26'd4200000;
    endcase
    return v;
  endfunction

  function automatic logic [PctW-1:0] soc_pct_q8(input logic [IdxW-1:0] idx);
    return PctW'(idx) * PctW'(PctStep);
  endfunction

endpackage

// ===== sv/battery_soc_estimator.sv =====
// Battery state-of-charge estimator.
// Input stream s_axis: one raw ADC sample per transfer. Output stream m_axis:
// one result per sample (pack microvolts, cell microvolts, percent in Q8).
// Configuration: cfg_valid_i/cfg_ready_o write channel, cfg_addr_i selects
// 0 cell count, 1 microvolts per count, 2 filter weight, 3 full-cell mV;
// other addresses are ignored. Write only while the block is idle.
// One sample is processed at a time: the next transfer is taken in the cycle
// after the result is loaded. The work per sample is the 26-step cell-count
// division and, when the cell voltage lies inside the table (not clamped to
// 0 or 100 percent), the binary table search (four or five steps) and the
// 11-step interpolation division, both divisions bit-serial on one shared
// divider, plus three passes through one shared multiplier (four inside the
// table, two more on the first sample after reset, for priming).
// Reset clears the filter: the first sample loads full-cell voltage times
// cell count before averaging. Configuration returns to its reset values.
// The output register holds a result until taken; a new sample is accepted
// meanwhile, and its result waits in the datapath while m_axis_tready is low.
module battery_soc_estimator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [11:0] adc_sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [25:0] pack_microvolts, [51:26] cell_microvolts,
                                      // [66:52] percent_q8
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_addr_i,
  input  logic [16:0] cfg_data_i
);

  localparam logic [3:0] RegCellCount  = 4'd0;
  localparam logic [3:0] RegUvPerCount = 4'd1;
  localparam logic [3:0] RegWeight     = 4'd2;
  localparam logic [3:0] RegFullCellMv = 4'd3;

  localparam int PackW = bse_pkg::PackW;
  localparam int PctW  = bse_pkg::PctW;

  bse_pkg::cfg_t    cfg_q;
  bse_pkg::status_t status;
  bse_pkg::op_e     op;

  logic             out_load;
  logic             out_valid_q;
  logic [PackW-1:0] pack_q, cell_q;
  logic [PctW-1:0]  pct_q;
  logic [PackW-1:0] dp_pack, dp_cell;
  logic [PctW-1:0]  dp_pct;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cell_count   <= bse_pkg::CellsW'(1);
      cfg_q.uv_per_count <= bse_pkg::UvPerCountW'(806);
      cfg_q.weight       <= bse_pkg::WeightW'(6554);
      cfg_q.full_cell_mv <= bse_pkg::FullCellW'(4200);
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        RegCellCount:  cfg_q.cell_count   <= cfg_data_i[bse_pkg::CellsW-1:0];
        RegUvPerCount: cfg_q.uv_per_count <= cfg_data_i[bse_pkg::UvPerCountW-1:0];
        RegWeight:     cfg_q.weight       <= cfg_data_i[bse_pkg::WeightW-1:0];
        RegFullCellMv: cfg_q.full_cell_mv <= cfg_data_i[bse_pkg::FullCellW-1:0];
        default: ;
      endcase
    end
  end

  bse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_i (out_valid_q),
    .out_ready_i (m_axis_tready),
    .out_load_o  (out_load),
    .status_i    (status),
    .op_o        (op)
  );

  bse_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_i      (op),
    .cfg_i     (cfg_q),
    .sample_i  (s_axis_tdata[bse_pkg::SampleW-1:0]),
    .status_o  (status),
    .pack_uv_o (dp_pack),
    .cell_uv_o (dp_cell),
    .pct_q8_o  (dp_pct)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pack_q <= dp_pack;
      cell_q <= dp_cell;
      pct_q  <= dp_pct;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, pct_q, cell_q, pack_q};

endmodule

// ===== sv/bse_ctrl.sv =====
`include "battery_soc_estimator_macros.svh"

module bse_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  output logic              out_load_o,
  input  bse_pkg::status_t  status_i,
  output bse_pkg::op_e      op_o
);

  localparam logic [4:0] S_IDLE       = 5'd0;
  localparam logic [4:0] S_PRIME_A    = 5'd1;
  localparam logic [4:0] S_PRIME_B    = 5'd2;
  localparam logic [4:0] S_PRIME_C    = 5'd3;
  localparam logic [4:0] S_SCALE      = 5'd4;
  localparam logic [4:0] S_MUL_NEW    = 5'd5;
  localparam logic [4:0] S_MUL_OLD    = 5'd6;
  localparam logic [4:0] S_FILTER     = 5'd7;
  localparam logic [4:0] S_CDIV_LOAD  = 5'd8;
  localparam logic [4:0] S_CDIV       = 5'd9;
  localparam logic [4:0] S_RANGE      = 5'd10;
  localparam logic [4:0] S_SEARCH     = 5'd11;
  localparam logic [4:0] S_INTERP_MUL = 5'd12;
  localparam logic [4:0] S_IDIV_LOAD  = 5'd13;
  localparam logic [4:0] S_IDIV       = 5'd14;
  localparam logic [4:0] S_PCT        = 5'd15;
  localparam logic [4:0] S_DONE       = 5'd16;

  logic [4:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    op_o       = bse_pkg::OpNone;
    out_load_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_o    = bse_pkg::OpAccept;
          state_d = status_i.primed ? S_SCALE : S_PRIME_A;
        end
      end
      S_PRIME_A: begin
        op_o    = bse_pkg::OpPrimeA;
        state_d = S_PRIME_B;
      end
      S_PRIME_B: begin
        op_o    = bse_pkg::OpPrimeB;
        state_d = S_PRIME_C;
      end
      S_PRIME_C: begin
        op_o    = bse_pkg::OpPrimeC;
        state_d = S_SCALE;
      end
      S_SCALE: begin
        op_o    = bse_pkg::OpScale;
        state_d = S_MUL_NEW;
      end
      S_MUL_NEW: begin
        op_o    = bse_pkg::OpMulNew;
        state_d = S_MUL_OLD;
      end
      S_MUL_OLD: begin
        op_o    = bse_pkg::OpMulOld;
        state_d = S_FILTER;
      end
      S_FILTER: begin
        op_o    = bse_pkg::OpFilter;
        state_d = S_CDIV_LOAD;
      end
      S_CDIV_LOAD: begin
        op_o    = bse_pkg::OpCdivLoad;
        state_d = S_CDIV;
      end
      S_CDIV: begin
        op_o = bse_pkg::OpDivStep;
        if (status_i.div_last) begin
          state_d = S_RANGE;
        end
      end
      S_RANGE: begin
        op_o    = bse_pkg::OpRange;
        state_d = (status_i.below_min || status_i.above_max) ? S_DONE : S_SEARCH;
      end
      S_SEARCH: begin
        if (status_i.seg_found) begin
          state_d = S_INTERP_MUL;
        end else begin
          op_o = bse_pkg::OpSearch;
        end
      end
      S_INTERP_MUL: begin
        op_o    = bse_pkg::OpInterpMul;
        state_d = S_IDIV_LOAD;
      end
      S_IDIV_LOAD: begin
        op_o    = bse_pkg::OpIdivLoad;
        state_d = S_IDIV;
      end
      S_IDIV: begin
        op_o = bse_pkg::OpDivStep;
        if (status_i.div_last) begin
          state_d = S_PCT;
        end
      end
      S_PCT: begin
        op_o    = bse_pkg::OpPct;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_i || out_ready_i) begin
          out_load_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `BSE_ASSERT_NEXT(a_accept_leaves_idle, clk_i, rst_ni, in_valid_i && in_ready_o, state_q != S_IDLE)
  `BSE_ASSERT(a_load_only_when_free, clk_i, rst_ni, out_load_o |-> (state_q == S_DONE && (!out_valid_i || out_ready_i)))
  `BSE_ASSERT_NEXT(a_cdiv_ends_in_range, clk_i, rst_ni, state_q == S_CDIV && status_i.div_last, state_q == S_RANGE)

endmodule

// ===== sv/bse_dp.sv =====
module bse_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bse_pkg::op_e                op_i,
  input  bse_pkg::cfg_t               cfg_i,
  input  logic [bse_pkg::SampleW-1:0] sample_i,
  output bse_pkg::status_t            status_o,
  output logic [bse_pkg::PackW-1:0]   pack_uv_o,
  output logic [bse_pkg::PackW-1:0]   cell_uv_o,
  output logic [bse_pkg::PctW-1:0]    pct_q8_o
);

  localparam int PackW = bse_pkg::PackW;
  localparam int IdxW  = bse_pkg::IdxW;
  localparam int MulAW = bse_pkg::MulAW;
  localparam int MulBW = bse_pkg::MulBW;
  localparam int ProdW = bse_pkg::ProdW;
  localparam int AccW  = bse_pkg::AccW;
  localparam int DivW  = bse_pkg::DivW;
  localparam int CntW  = bse_pkg::CntW;
  localparam int ShW   = AccW - bse_pkg::FracBits;
  localparam int EffSampleW =
    (bse_pkg::AdcBits < bse_pkg::SampleW) ? bse_pkg::AdcBits : bse_pkg::SampleW;

  logic [bse_pkg::SampleW-1:0] sample_q;
  logic [bse_pkg::CellsW-1:0]  cells_q;
  logic [MulBW-1:0]            w_q;
  logic [ProdW-1:0]            prod_q;
  logic [AccW-1:0]             acc_q;
  logic [PackW-1:0]            avg_q;
  logic                        primed_q;
  logic [DivW-1:0]             rem_q;
  logic [PackW-1:0]            qd_q;
  logic [DivW-1:0]             div_q;
  logic [CntW-1:0]             cnt_q;
  logic [PackW-1:0]            cell_q;
  logic [IdxW-1:0]             lo_q, hi_q;
  logic [bse_pkg::PctW-1:0]    pct_q;

  logic [MulAW-1:0]   mul_a;
  logic [MulBW-1:0]   mul_b;
  logic [ProdW-1:0]   prod_d;
  logic [AccW-1:0]    sum;
  logic [ShW-1:0]     sum_sh;
  logic [DivW:0]      trial;
  logic               trial_ge;
  logic [IdxW-1:0]    mid;
  logic [PackW-1:0]   v_lo, v_hi, v_mid;
  logic [DivW-1:0]    seg_dv;
  logic [MulAW-1:0]   num;
  logic [PackW-1:0]   seg_off;

  assign v_lo    = bse_pkg::soc_volt_uv(lo_q);
  assign v_hi    = bse_pkg::soc_volt_uv(hi_q);
  assign mid     = IdxW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
  assign v_mid   = bse_pkg::soc_volt_uv(mid);
  assign seg_dv  = DivW'(v_hi - v_lo);
  assign seg_off = cell_q - v_lo;
  assign num     = prod_q[MulAW-1:0] + MulAW'(seg_dv >> 1);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_i)
      bse_pkg::OpPrimeA: begin
        mul_a = MulAW'(cfg_i.full_cell_mv);
        mul_b = MulBW'(bse_pkg::MvToUv);
      end
      bse_pkg::OpPrimeB: begin
        mul_a = prod_q[MulAW-1:0];
        mul_b = MulBW'(cells_q);
      end
      bse_pkg::OpScale: begin
        mul_a = MulAW'(sample_q);
        mul_b = MulBW'(cfg_i.uv_per_count);
      end
      bse_pkg::OpMulNew: begin
        mul_a = prod_q[MulAW-1:0];
        mul_b = w_q;
      end
      bse_pkg::OpMulOld: begin
        mul_a = MulAW'(avg_q);
        mul_b = MulBW'(bse_pkg::WeightOne) - w_q;
      end
      bse_pkg::OpInterpMul: begin
        mul_a = MulAW'(seg_off);
        mul_b = MulBW'(bse_pkg::PctStep);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d   = ProdW'(mul_a) * ProdW'(mul_b);
  assign sum      = acc_q + AccW'(prod_q);
  assign sum_sh   = sum[AccW-1:bse_pkg::FracBits];
  assign trial    = {rem_q, qd_q[PackW-1]};
  assign trial_ge = (trial >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q <= 1'b0;
      cnt_q    <= '0;
      lo_q     <= '0;
      hi_q     <= '0;
    end else begin
      case (op_i)
        bse_pkg::OpFilter:   primed_q <= 1'b1;
        bse_pkg::OpCdivLoad: cnt_q <= CntW'(PackW);
        bse_pkg::OpIdivLoad: cnt_q <= CntW'(bse_pkg::IdivBits);
        bse_pkg::OpDivStep:  cnt_q <= cnt_q - 1'b1;
        bse_pkg::OpRange: begin
          lo_q <= '0;
          hi_q <= IdxW'(bse_pkg::TablePoints - 1);
        end
        bse_pkg::OpSearch: begin
          if (cell_q <= v_mid) begin
            hi_q <= mid;
          end else begin
            lo_q <= mid;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      bse_pkg::OpAccept: begin
        sample_q <= bse_pkg::SampleW'(sample_i[EffSampleW-1:0]);
        cells_q  <= (cfg_i.cell_count == '0) ? bse_pkg::CellsW'(1) : cfg_i.cell_count;
        w_q      <= (cfg_i.weight > MulBW'(bse_pkg::WeightOne)) ?
                    MulBW'(bse_pkg::WeightOne) : cfg_i.weight;
      end
      bse_pkg::OpPrimeA, bse_pkg::OpPrimeB, bse_pkg::OpScale,
      bse_pkg::OpMulNew, bse_pkg::OpInterpMul: begin
        prod_q <= prod_d;
      end
      bse_pkg::OpMulOld: begin
        prod_q <= prod_d;
        acc_q  <= AccW'(prod_q) + AccW'(bse_pkg::RoundHalf);
      end
      bse_pkg::OpPrimeC: begin
        avg_q <= (prod_q > ProdW'(bse_pkg::PackMax)) ? bse_pkg::PackMax : prod_q[PackW-1:0];
      end
      bse_pkg::OpFilter: begin
        avg_q <= (sum_sh > ShW'(bse_pkg::PackMax)) ? bse_pkg::PackMax : sum_sh[PackW-1:0];
      end
      bse_pkg::OpCdivLoad: begin
        rem_q <= '0;
        qd_q  <= avg_q;
        div_q <= DivW'(cells_q);
      end
      bse_pkg::OpDivStep: begin
        rem_q <= trial_ge ? DivW'(trial - {1'b0, div_q}) : trial[DivW-1:0];
        qd_q  <= {qd_q[PackW-2:0], trial_ge};
      end
      bse_pkg::OpRange: begin
        cell_q <= qd_q;
        if (qd_q <= bse_pkg::soc_volt_uv('0)) begin
          pct_q <= bse_pkg::soc_pct_q8('0);
        end else begin
          pct_q <= bse_pkg::soc_pct_q8(IdxW'(bse_pkg::TablePoints - 1));
        end
      end
      bse_pkg::OpIdivLoad: begin
        rem_q <= DivW'(num >> bse_pkg::IdivBits);
        qd_q  <= {num[bse_pkg::IdivBits-1:0], (PackW - bse_pkg::IdivBits)'(0)};
        div_q <= seg_dv;
      end
      bse_pkg::OpPct: begin
        pct_q <= bse_pkg::soc_pct_q8(lo_q) +
                 bse_pkg::PctW'(qd_q[bse_pkg::IdivBits-1:0]);
      end
      default: ;
    endcase
  end

  assign status_o.primed    = primed_q;
  assign status_o.div_last  = (cnt_q == CntW'(1));
  assign status_o.below_min = (qd_q <= bse_pkg::soc_volt_uv('0));
  assign status_o.above_max = (qd_q > bse_pkg::soc_volt_uv(IdxW'(bse_pkg::TablePoints - 1)));
  assign status_o.seg_found = (hi_q == lo_q + IdxW'(1));

  assign pack_uv_o = avg_q;
  assign cell_uv_o = cell_q;
  assign pct_q8_o  = pct_q;

endmodule

// ===== tb/sv/tb_battery_soc_estimator.sv =====
module tb_battery_soc_estimator;
  import bse_pkg::*;

  localparam logic [3:0] RegCellCount  = 4'd0;
  localparam logic [3:0] RegUvPerCount = 4'd1;
  localparam logic [3:0] RegWeight     = 4'd2;
  localparam logic [3:0] RegFullCellMv = 4'd3;
  localparam logic [3:0] RegUnmapped   = 4'd7;

  localparam int CycleLimit   = 1000000;
  localparam int HoldCycles   = 500;
  localparam int RandomPhases = 8;
  localparam int PhaseItems   = 200;

  localparam longint unsigned SocTableUv [TablePoints] = '{
    3300000, 3500000, 3600000, 3650000, 3680000, 3700000, 3720000,
    3740000, 3760000, 3780000, 3800000, 3830000, 3850000, 3880000,
    3920000, 3960000, 4000000, 4060000, 4100000, 4150000, 4200000
  };

  typedef struct packed {
    logic [PackW-1:0] pack_uv;
    logic [PackW-1:0] cell_uv;
    logic [PctW-1:0]  pct_q8;
  } soc_result_t;

  typedef struct packed {
    logic [3:0]  addr;
    logic [16:0] data;
  } reg_write_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_addr_i = '0;
  logic [16:0] cfg_data_i = '0;

  logic [15:0]  sample_q[$];
  reg_write_t   reg_write_q[$];
  soc_result_t  soc_expect_q[$];

  // shadow of the block's registers and filter state
  longint unsigned shd_cells, shd_uv, shd_weight, shd_full_mv;
  longint unsigned pack_avg;
  bit              avg_primed;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int hold_reqs      = 0;
  int hold_seen;
  int hold_left;
  int cycle_count    = 0;
  int n_errors       = 0;
  int n_results      = 0;
  int n_samples      = 0;

  battery_soc_estimator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic longint unsigned clamp_pack(input longint unsigned v);
    return (v > longint'(PackMax)) ? longint'(PackMax) : v;
  endfunction

  function automatic soc_result_t estimate_soc(input logic [15:0] raw);
    longint unsigned cells, w, scaled, cell_v, dv, pct;
    bit              found;
    soc_result_t     r;
    cells = (shd_cells == 0) ? 1 : shd_cells;
    w = (shd_weight > WeightOne) ? WeightOne : shd_weight;
    scaled = longint'(raw[AdcBits-1:0]) * shd_uv;
    if (!avg_primed) begin
      pack_avg = clamp_pack(shd_full_mv * MvToUv * cells);
      avg_primed = 1'b1;
    end
    pack_avg = clamp_pack((scaled * w + pack_avg * (WeightOne - w) + RoundHalf) >> FracBits);
    cell_v = pack_avg / cells;
    pct = (TablePoints - 1) * PctStep;
    found = 1'b0;
    if (cell_v <= SocTableUv[0]) begin
      pct = 0;
    end else begin
      for (int i = 1; i < TablePoints; i++) begin
        if (!found && cell_v <= SocTableUv[i]) begin
          dv = SocTableUv[i] - SocTableUv[i-1];
          pct = (i - 1) * PctStep + ((cell_v - SocTableUv[i-1]) * PctStep + dv / 2) / dv;
          found = 1'b1;
        end
      end
    end
    r.pack_uv = pack_avg[PackW-1:0];
    r.cell_uv = cell_v[PackW-1:0];
    r.pct_q8  = pct[PctW-1:0];
    return r;
  endfunction

  // sample driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      pack_avg = 0;
      avg_primed = 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        soc_expect_q.push_back(estimate_soc(s_axis_tdata));
        n_samples++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (sample_q.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= sample_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
          s_axis_tdata  <= 16'($urandom);
        end
      end
    end
  end

  // register write driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_valid_i <= 1'b0;
      shd_cells   <= 1;
      shd_uv      <= 806;
      shd_weight  <= 6554;
      shd_full_mv <= 4200;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_addr_i)
          RegCellCount:  shd_cells   <= cfg_data_i[CellsW-1:0];
          RegUvPerCount: shd_uv      <= cfg_data_i[UvPerCountW-1:0];
          RegWeight:     shd_weight  <= cfg_data_i[WeightW-1:0];
          RegFullCellMv: shd_full_mv <= cfg_data_i[FullCellW-1:0];
          default: ;
        endcase
      end
      if (!cfg_valid_i || cfg_ready_o) begin
        if (reg_write_q.size() > 0) begin
          cfg_valid_i <= 1'b1;
          {cfg_addr_i, cfg_data_i} <= reg_write_q.pop_front();
        end else begin
          cfg_valid_i <= 1'b0;
        end
      end
    end
  end

  // long output hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_seen <= 0;
      hold_left <= 0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    soc_result_t got, exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{pack_uv: m_axis_tdata[25:0], cell_uv: m_axis_tdata[51:26],
              pct_q8: m_axis_tdata[66:52]};
      n_results++;
      if (soc_expect_q.size() == 0) begin
        $error("result transfer with no sample pending: pack %0d", got.pack_uv);
        n_errors++;
      end else begin
        exp_r = soc_expect_q.pop_front();
        if (got.pack_uv !== exp_r.pack_uv) begin
          $error("pack_microvolts: expected %0d, got %0d", exp_r.pack_uv, got.pack_uv);
          n_errors++;
        end
        if (got.cell_uv !== exp_r.cell_uv) begin
          $error("cell_microvolts: expected %0d, got %0d", exp_r.cell_uv, got.cell_uv);
          n_errors++;
        end
        if (got.pct_q8 !== exp_r.pct_q8) begin
          $error("percent_q8: expected %0d, got %0d", exp_r.pct_q8, got.pct_q8);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_count,
               soc_expect_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [3:0] addr, input int unsigned data);
    reg_write_q.push_back('{addr: addr, data: data[16:0]});
  endtask

  task automatic write_all(input int unsigned cells, input int unsigned uv,
                           input int unsigned w, input int unsigned full_mv);
    write_reg(RegCellCount, cells);
    write_reg(RegUvPerCount, uv);
    write_reg(RegWeight, w);
    write_reg(RegFullCellMv, full_mv);
  endtask

  task automatic wait_idle();
    while (sample_q.size() > 0 || s_axis_tvalid || soc_expect_q.size() > 0 ||
           reg_write_q.size() > 0 || cfg_valid_i) begin
      @(negedge clk_i);
    end
    repeat (8) @(negedge clk_i);
  endtask

  initial begin
    int unsigned cells, eff_cells, uv, w, smp;
    logic [15:0] raw;
    bit          near_table;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (4) @(negedge clk_i);

    // saturated priming, frozen average, upper sample bits set
    write_all(15, 65535, 0, 8191);
    wait_idle();
    sample_q.push_back(16'h0fff);
    sample_q.push_back(16'h0000);
    sample_q.push_back(16'hf000);
    wait_idle();

    // zero cell count, oversized weight: average tracks sample*1000 directly
    write_all(0, 1000, 131071, 0);
    wait_idle();
    foreach (SocTableUv[i]) if (i < 2) sample_q.push_back(16'(SocTableUv[i] / 1000));
    sample_q.push_back(16'd0);
    sample_q.push_back(16'd3299);
    sample_q.push_back(16'd3301);
    sample_q.push_back(16'd3650);
    sample_q.push_back(16'd3999);
    sample_q.push_back(16'd4000);
    sample_q.push_back(16'd4095);
    wait_idle();

    // top of table exactly, then above it
    write_reg(RegUvPerCount, 1050);
    wait_idle();
    sample_q.push_back(16'd4000);
    sample_q.push_back(16'd4001);
    sample_q.push_back(16'hffff);
    wait_idle();

    write_all(8, 8400, 65536, 3000);
    wait_idle();
    sample_q.push_back(16'd4000);
    sample_q.push_back(16'd1);
    wait_idle();

    write_reg(RegUvPerCount, 0);
    write_reg(RegWeight, 1);
    write_reg(RegUnmapped, 17'h1ffff);
    wait_idle();
    sample_q.push_back(16'd4095);
    sample_q.push_back(16'd0);
    wait_idle();

    // back-pressure: output held off while samples keep coming
    write_all(4, 4200, 40000, 4200);
    wait_idle();
    hold_reqs = hold_reqs + 1;
    repeat (40) sample_q.push_back(16'($urandom_range(3000, 4095)));
    wait_idle();

    for (int p = 0; p < RandomPhases; p++) begin
      case (p % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 69; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 69; end
        default: begin src_idle_pct = 15; sink_stall_pct = 15; end
      endcase
      cells = $urandom_range(0, 15);
      eff_cells = (cells == 0) ? 1 : cells;
      near_table = (p != 5);
      uv = near_table ? eff_cells * 1050 - $urandom_range(0, 200) : $urandom_range(0, 65535);
      w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071) : $urandom_range(8192, 65536);
      write_all(cells, uv, w, $urandom_range(0, 8191));
      wait_idle();
      for (int k = 0; k < PhaseItems; k++) begin
        raw = 16'($urandom);
        smp = (near_table && $urandom_range(0, 9) != 0) ? $urandom_range(3100, 4095)
                                                       : $urandom_range(0, 4095);
        raw[11:0] = smp[11:0];
        sample_q.push_back(raw);
      end
      wait_idle();
    end

    repeat (70) @(negedge clk_i);
    $display("Ran %0d samples and checked %0d results across directed, hold-off and",
             n_samples, n_results);
    $display("%0d randomized register settings with sender and receiver gaps", RandomPhases);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
